// File: hw/rtl/ubag_pkg.sv
// Shared types and constants for the unordered bag with swap removal.
`timescale 1ns / 1ps
`default_nettype none

package ubag_pkg;

  localparam int DEF_CAPACITY  = 16;
  localparam int DEF_ELEM_BITS = 32;

  localparam int REQ_W      = 3;
  localparam int VALUE_W    = 32;
  localparam int INDEX_W    = 4;
  localparam int COUNT_W    = 5;
  localparam int S_DATA_W   = 40;
  localparam int M_DATA_W   = 40;

  localparam int DEF_IDX_W  = $clog2(DEF_CAPACITY);
  localparam int DEF_CNT_W  = $clog2(DEF_CAPACITY + 1);
  localparam int DEF_CMP_W  = (DEF_CNT_W > INDEX_W) ? DEF_CNT_W : INDEX_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT     = 3'd0,
    REQ_REMOVE_IDX = 3'd1,
    REQ_REMOVE_LST = 3'd2,
    REQ_REMOVE_VAL = 3'd3,
    REQ_CONTAINS   = 3'd4,
    REQ_GET        = 3'd5,
    REQ_CLEAR      = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  // Default shapes of the token, broadcast and write groups, for the default parameters.
  typedef struct packed {
    logic                     valid;
    logic                     hit;
    logic [DEF_IDX_W-1:0]     pos;
    logic [DEF_ELEM_BITS-1:0] data;
    logic [DEF_ELEM_BITS-1:0] last;
  } def_tok_t;

  typedef struct packed {
    logic                     match_en;
    logic [DEF_ELEM_BITS-1:0] key;
    logic [DEF_CMP_W-1:0]     idx;
    logic [DEF_CMP_W-1:0]     count;
    logic [DEF_CMP_W-1:0]     last_pos;
  } def_bc_t;

  typedef struct packed {
    logic                     en;
    logic [DEF_IDX_W-1:0]     pos;
    logic [DEF_ELEM_BITS-1:0] data;
  } def_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/unordered_bag_swap_remove.sv
// Top level of the unordered bag: request decoding, scan control and result register.
//
// Requests arrive on the slave stream: tuser carries the request kind, tdata the
// value and the index. Every request yields exactly one result item on the master
// stream, carrying the read value, the found flag, a status code and the count of
// entries held afterwards.
// Insert, clear, unknown kinds and requests rejected up front (full, empty or an
// index out of range) complete at once: the result is valid on the cycle after
// the request is taken. Remove at index, remove last, remove by value, contains
// and get send a token down the row of CAPACITY cells, one cell per cycle. When
// it leaves the last cell it is captured and the scan moves to its final step,
// which loads the result register; the length of the cell row sets the delay.
// One request is in progress at a time, until its result is loaded.
// A new request is taken while idle, provided the result register is empty or is
// being emptied in the same cycle. When the receiver stalls, a finished scan waits
// in its final step and no further request is taken. Reset empties the bag and
// the result register; entry contents are left undefined and are never read
// before being written.
`timescale 1ns / 1ps
`default_nettype none

module unordered_bag_swap_remove #(
  parameter int CAPACITY  = ubag_pkg::DEF_CAPACITY,
  parameter int ELEM_BITS = ubag_pkg::DEF_ELEM_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // value [31:0], index [35:32], zero [39:36]
  input  wire logic [ubag_pkg::S_DATA_W-1:0] s_axis_tdata,
  // req_type [2:0]
  input  wire logic [ubag_pkg::REQ_W-1:0]    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // read_value [31:0], found [32], status [34:33], count [39:35]
  output logic [ubag_pkg::M_DATA_W-1:0]      m_axis_tdata
);
  import ubag_pkg::*;

  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = (CntW > INDEX_W) ? CntW : INDEX_W;

  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic [IdxW-1:0]      pos;
    logic [ELEM_BITS-1:0] data;
    logic [ELEM_BITS-1:0] last;
  } tok_t;

  typedef struct packed {
    logic                 match_en;
    logic [ELEM_BITS-1:0] key;
    logic [CmpW-1:0]      idx;
    logic [CmpW-1:0]      count;
    logic [CmpW-1:0]      last_pos;
  } bc_t;

  typedef struct packed {
    logic                 en;
    logic [IdxW-1:0]      pos;
    logic [ELEM_BITS-1:0] data;
  } wr_t;

  state_e          state_q, state_d;
  req_e            req_q, req_d;
  req_e            in_req;
  bc_t             bc_q, bc_d;
  logic            inject_q, inject_d;
  tok_t            res_q, res_d;
  logic [CntW-1:0] count_q, count_d;
  wr_t             wr;

  logic            out_valid_q, out_valid_d;
  logic [31:0]     rd_q, rd_d;
  logic            found_q, found_d;
  status_e         status_q, status_d;
  logic [4:0]      count_out_q, count_out_d;

  tok_t                 chain [CAPACITY+1];
  logic [ELEM_BITS-1:0] in_key;
  logic [CmpW-1:0]      in_idx;
  logic [CmpW-1:0]      cnt_c;
  logic                 out_free;
  logic                 accept;
  logic                 load_out;

  assign in_req   = req_e'(s_axis_tuser);
  assign in_key   = ELEM_BITS'(s_axis_tdata[VALUE_W-1:0]);
  assign in_idx   = CmpW'(s_axis_tdata[VALUE_W+INDEX_W-1:VALUE_W]);
  assign cnt_c    = CmpW'(count_q);
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = inject_q;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ubag_cell #(
      .CAPACITY (CAPACITY),
      .ELEM_BITS(ELEM_BITS),
      .POS      (g),
      .tok_t    (tok_t),
      .bc_t     (bc_t),
      .wr_t     (wr_t)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (chain[g]),
      .tok_o (chain[g+1]),
      .bc_i  (bc_q),
      .wr_i  (wr)
    );
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    bc_d        = bc_q;
    inject_d    = 1'b0;
    res_d       = res_q;
    count_d     = count_q;
    wr          = '0;
    load_out    = 1'b0;
    rd_d        = '0;
    found_d     = 1'b0;
    status_d    = STAT_OK;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d            = in_req;
          bc_d.match_en    = (in_req == REQ_REMOVE_VAL) || (in_req == REQ_CONTAINS);
          bc_d.key         = in_key;
          bc_d.idx         = in_idx;
          bc_d.count       = cnt_c;
          bc_d.last_pos    = cnt_c - CmpW'(1);
          unique case (in_req) inside
            REQ_INSERT: begin
              load_out = 1'b1;
              if (count_q == CntW'(CAPACITY)) begin
                status_d = STAT_FULL;
              end else begin
                wr.en    = 1'b1;
                wr.pos   = IdxW'(count_q);
                wr.data  = in_key;
                count_d  = count_q + CntW'(1);
              end
            end
            REQ_REMOVE_IDX, REQ_GET: begin
              if (in_idx >= cnt_c) begin
                load_out = 1'b1;
                status_d = STAT_RANGE;
              end else begin
                inject_d = 1'b1;
                state_d  = ST_SCAN;
              end
            end
            REQ_REMOVE_LST: begin
              if (count_q == '0) begin
                load_out = 1'b1;
                status_d = STAT_RANGE;
              end else begin
                inject_d = 1'b1;
                state_d  = ST_SCAN;
              end
            end
            REQ_REMOVE_VAL, REQ_CONTAINS: begin
              if (count_q == '0) begin
                load_out = 1'b1;
              end else begin
                inject_d = 1'b1;
                state_d  = ST_SCAN;
              end
            end
            REQ_CLEAR: begin
              load_out = 1'b1;
              count_d  = '0;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (chain[CAPACITY].valid) begin
          res_d   = chain[CAPACITY];
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
          unique case (req_q) inside
            REQ_REMOVE_IDX, REQ_REMOVE_VAL: begin
              found_d = (req_q == REQ_REMOVE_VAL) && res_q.hit;
              if (res_q.hit) begin
                wr.en   = 1'b1;
                wr.pos  = res_q.pos;
                wr.data = res_q.last;
                count_d = count_q - CntW'(1);
                rd_d    = 32'(res_q.data);
              end
            end
            REQ_REMOVE_LST: begin
              count_d = count_q - CntW'(1);
              rd_d    = 32'(res_q.last);
            end
            REQ_CONTAINS: begin
              found_d = res_q.hit;
            end
            REQ_GET: begin
              rd_d = 32'(res_q.data);
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    count_out_d = 5'(count_d);
    out_valid_d = load_out || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      inject_q    <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      inject_q    <= inject_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    bc_q  <= bc_d;
    res_q <= res_d;
    if (load_out) begin
      rd_q        <= rd_d;
      found_q     <= found_d;
      status_q    <= status_d;
      count_out_q <= count_out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {count_out_q, status_q, found_q, rd_q};

endmodule

`default_nettype wire

// File: hw/rtl/ubag_cell.sv
// One storage cell of the bag: holds an entry and inspects the passing scan token.
`timescale 1ns / 1ps
`default_nettype none

module ubag_cell #(
  parameter int  CAPACITY  = ubag_pkg::DEF_CAPACITY,
  parameter int  ELEM_BITS = ubag_pkg::DEF_ELEM_BITS,
  parameter int  POS       = 0,
  parameter type tok_t     = ubag_pkg::def_tok_t,
  parameter type bc_t      = ubag_pkg::def_bc_t,
  parameter type wr_t      = ubag_pkg::def_wr_t
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire tok_t tok_i,
  output tok_t      tok_o,
  input  wire bc_t  bc_i,
  input  wire wr_t  wr_i
);
  import ubag_pkg::*;

  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = (CntW > INDEX_W) ? CntW : INDEX_W;
  localparam logic [IdxW-1:0] PosI = IdxW'(POS);
  localparam logic [CmpW-1:0] PosC = CmpW'(POS);

  logic [ELEM_BITS-1:0] entry_q;
  tok_t                 tok_q;
  tok_t                 tok_d;

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid) begin
      if (bc_i.match_en) begin
        if (!tok_i.hit && (PosC < bc_i.count) && (entry_q == bc_i.key)) begin
          tok_d.hit  = 1'b1;
          tok_d.pos  = PosI;
          tok_d.data = entry_q;
        end
      end else if (PosC == bc_i.idx) begin
        tok_d.hit  = 1'b1;
        tok_d.pos  = PosI;
        tok_d.data = entry_q;
      end
      if (PosC == bc_i.last_pos) begin
        tok_d.last = entry_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.pos == PosI)) begin
      entry_q <= wr_i.data;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// File: tb/ubag_checker.sv
// Stream watcher for the unordered bag: predicts every request's result and checks it.
`timescale 1ns / 1ps

module ubag_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  // value [31:0], index [35:32], zero [39:36]
  input  logic [ubag_pkg::S_DATA_W-1:0] s_tdata_i,
  // req_type [2:0]
  input  logic [ubag_pkg::REQ_W-1:0]    s_tuser_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  // read_value [31:0], found [32], status [34:33], count [39:35]
  input  logic [ubag_pkg::M_DATA_W-1:0] m_tdata_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);

  import ubag_pkg::*;

  localparam int CAP = DEF_CAPACITY;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    status_e            status;
    logic               found;
    logic [VALUE_W-1:0] read_value;
  } bag_result_t;

  logic [VALUE_W-1:0] bag_mem [CAP];
  logic [COUNT_W-1:0] bag_fill;
  bag_result_t        result_queue [$];
  int                 fail_count;
  int                 checked;

  assign fail_count_o = fail_count;
  assign pending_o    = result_queue.size();
  assign checked_o    = checked;

  function automatic bag_result_t predict_request(logic [REQ_W-1:0] kind,
                                                  logic [VALUE_W-1:0] key,
                                                  logic [INDEX_W-1:0] pos);
    bag_result_t res;
    int          hit_pos;
    res        = '0;
    res.status = STAT_OK;
    hit_pos    = -1;
    case (kind)
      REQ_INSERT: begin
        if (bag_fill >= CAP) begin
          res.status = STAT_FULL;
        end else begin
          bag_mem[bag_fill[INDEX_W-1:0]] = key;
          bag_fill++;
        end
      end
      REQ_REMOVE_IDX: begin
        if ({1'b0, pos} >= bag_fill) begin
          res.status = STAT_RANGE;
        end else begin
          res.read_value = bag_mem[pos];
          bag_fill--;
          bag_mem[pos] = bag_mem[bag_fill[INDEX_W-1:0]];
        end
      end
      REQ_REMOVE_LST: begin
        if (bag_fill == 0) begin
          res.status = STAT_RANGE;
        end else begin
          bag_fill--;
          res.read_value = bag_mem[bag_fill[INDEX_W-1:0]];
        end
      end
      REQ_REMOVE_VAL, REQ_CONTAINS: begin
        for (int i = 0; i < bag_fill; i++) begin
          if (hit_pos < 0 && bag_mem[INDEX_W'(i)] == key) hit_pos = i;
        end
        if (hit_pos >= 0) begin
          res.found = 1'b1;
          if (kind == REQ_REMOVE_VAL) begin
            res.read_value = bag_mem[INDEX_W'(hit_pos)];
            bag_fill--;
            bag_mem[INDEX_W'(hit_pos)] = bag_mem[bag_fill[INDEX_W-1:0]];
          end
        end
      end
      REQ_GET: begin
        if ({1'b0, pos} >= bag_fill) begin
          res.status = STAT_RANGE;
        end else begin
          res.read_value = bag_mem[pos];
        end
      end
      REQ_CLEAR: begin
        bag_fill = '0;
      end
      default: begin
      end
    endcase
    res.count = bag_fill;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: result %0d, %s: expected %0h, got %0h", $time, checked, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bag_result_t got;
    bag_result_t want;
    if (!rst_ni) begin
      bag_fill = '0;
      result_queue.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        if (result_queue.size() == 0) begin
          report_mismatch("item with no request waiting", '0, got.read_value);
        end else begin
          want = result_queue.pop_front();
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, got.read_value);
          if (got.found !== want.found)
            report_mismatch("found", 32'(want.found), 32'(got.found));
          if (got.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(got.status));
          if (got.count !== want.count)
            report_mismatch("count", 32'(want.count), 32'(got.count));
        end
        checked++;
      end
      if (s_tvalid_i && s_tready_i) begin
        result_queue.push_back(predict_request(s_tuser_i, s_tdata_i[31:0], s_tdata_i[35:32]));
      end
    end
  end

endmodule

// File: tb/testbench.sv
// Top of the unordered bag testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module testbench;

  import ubag_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 1925;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 400;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  logic [REQ_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;

  int fail_count;
  int pending;
  int checked;
  int items_sent = 0;
  int directed_items;
  bit calm_send = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  unordered_bag_swap_remove u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ubag_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(logic [REQ_W-1:0] kind, logic [VALUE_W-1:0] value,
                              logic [INDEX_W-1:0] index);
    int gap;
    gap = gap_len(calm_send);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, index, value};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  initial begin
    logic [REQ_W-1:0]   kind;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value_pool [8];
    int                 insert_pct;
    int                 r;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Every read and remove request on an empty bag, and the unused request kind.
    send_request(REQ_GET, 32'h0, 4'd15);
    send_request(REQ_REMOVE_IDX, 32'h0, 4'd0);
    send_request(REQ_REMOVE_LST, 32'h0, 4'd0);
    send_request(REQ_REMOVE_VAL, 32'hFFFF_FFFF, 4'd0);
    send_request(REQ_CONTAINS, 32'h0, 4'd0);
    send_request(REQ_UNUSED, 32'h1234_5678, 4'd7);
    // Fill to capacity with the extreme values and a duplicate of zero.
    for (int k = 0; k < DEF_CAPACITY; k++) begin
      if (k == 0 || k == 2) value = 32'h0;
      else if (k == 1) value = 32'hFFFF_FFFF;
      else value = $urandom;
      send_request(REQ_INSERT, value, INDEX_W'(k));
    end
    send_request(REQ_INSERT, 32'hA5A5_5A5A, 4'd15);
    send_request(REQ_REMOVE_IDX, 32'h0, 4'd15);
    send_request(REQ_REMOVE_VAL, 32'h0, 4'd0);
    send_request(REQ_CONTAINS, 32'hFFFF_FFFF, 4'd0);
    send_request(REQ_CLEAR, 32'h0, 4'd0);
    directed_items = items_sent;

    // A small pool of values makes searches hit often.
    value_pool[0] = 32'h0;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < 8; k++) value_pool[k] = $urandom;
    insert_pct = 45;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 70;
          1: insert_pct = 20;
          default: insert_pct = 45;
        endcase
      end
      if (n % 150 == 0) calm_send = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r == 0) begin
        kind = REQ_CLEAR;
      end else if (r == 1) begin
        kind = REQ_UNUSED;
      end else if (r < 2 + insert_pct) begin
        kind = REQ_INSERT;
      end else begin
        case ($urandom_range(0, 4))
          0: kind = REQ_REMOVE_IDX;
          1: kind = REQ_REMOVE_LST;
          2: kind = REQ_REMOVE_VAL;
          3: kind = REQ_CONTAINS;
          default: kind = REQ_GET;
        endcase
      end
      value = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 7)] : $urandom;
      index = ($urandom_range(0, 9) < 7) ? INDEX_W'($urandom_range(0, 7))
                                         : INDEX_W'($urandom_range(0, 15));
      send_request(kind, value, index);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2 * DEF_CAPACITY + 10) @(negedge clk_i);

    $display("Run covered %0d requests (%0d directed, the rest random) and %0d checked results,",
             items_sent, directed_items, checked);
    $display("with one receiver hold-off of %0d cycles while requests kept coming.", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Result side: random back-pressure, calm stretches and one long hold-off.
  initial begin
    int  stall;
    int  cycles;
    bit  calm_recv;
    bit  hold_done;
    stall     = 0;
    cycles    = 0;
    calm_recv = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      cycles++;
      if (cycles % 256 == 0) calm_recv = ($urandom_range(0, 3) == 0);
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        stall = gap_len(calm_recv);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results still outstanding.", pending);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
